[design/tpt_pkg.sv]
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared constants, event codes and controller/datapath handshake types for
// the touch point tracker.
// ----------------------------------------------------------------------------
package tpt_pkg;

  // Table and frame sizes
  localparam int MAX_POINTS = 2;
  localparam int IN_POINTS  = 2;
  localparam int WORK_SIZE  = MAX_POINTS + IN_POINTS;
  localparam int PT_LIMIT   = (MAX_POINTS < IN_POINTS) ? MAX_POINTS : IN_POINTS;

  // Field widths
  localparam int COORD_W = 11;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int NPTS_W  = 2;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int WCNT_W  = $clog2(WORK_SIZE + 1);
  localparam int WIDX_W  = $clog2(WORK_SIZE);
  localparam int IDX_W   = 1;

  localparam logic [COORD_W-1:0] RADIUS_RESET = COORD_W'(8);

  // Event codes on the result channel
  typedef enum logic [1:0] {
    EV_DOWN    = 2'd0,
    EV_MOVE    = 2'd1,
    EV_RELEASE = 2'd2
  } ev_kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             pt_step;
    logic             rel_step;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } tpt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [NPTS_W-1:0] n_pts;
    logic [CNT_W-1:0]  old_cnt;
    logic              pt_emit;
    logic              rel_emit;
    logic              can_push;
  } tpt_status_t;

endpackage

[design/tpt_ctrl.sv]
// ----------------------------------------------------------------------------
// tpt_ctrl
// Frame sequencer: accepts a frame, steps through its points, then through
// the tracked touches for releases, then commits the compacted table.
// ----------------------------------------------------------------------------
module tpt_ctrl import tpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tpt_status_t st,
  output tpt_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POINT = 4'b0010,
    S_REL   = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Next-state and command decode
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    cmd.idx   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_POINT;
          idx_nxt   = '0;
        end
      end
      S_POINT: begin
        if (NPTS_W'(idx_r) >= st.n_pts) begin
          state_nxt = S_REL;
          idx_nxt   = '0;
        end else if (!st.pt_emit || st.can_push) begin
          cmd.pt_step = 1'b1;
          if (NPTS_W'(idx_r) == st.n_pts - NPTS_W'(1)) begin
            state_nxt = S_REL;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      S_REL: begin
        if (CNT_W'(idx_r) >= st.old_cnt) begin
          state_nxt = S_FIN;
        end else if (!st.rel_emit || st.can_push) begin
          cmd.rel_step = 1'b1;
          if (CNT_W'(idx_r) == st.old_cnt - CNT_W'(1)) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      S_FIN: begin
        if (st.can_push) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the input side off while a frame is in work
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

[design/tpt_datapath.sv]
// ----------------------------------------------------------------------------
// tpt_datapath
// Touch table, working copy for one frame, point matcher, pending event
// word and output register.
// ----------------------------------------------------------------------------
module tpt_datapath import tpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_wdata,
  // frame word
  input  logic [NPTS_W-1:0]  in_point_count,
  input  logic [COORD_W-1:0] in_first_x,
  input  logic [COORD_W-1:0] in_first_y,
  input  logic [COORD_W-1:0] in_second_x,
  input  logic [COORD_W-1:0] in_second_y,
  input  logic [TIME_W-1:0]  in_frame_time,
  // controller link
  input  tpt_cmd_t           cmd,
  output tpt_status_t        st,
  // event word
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [ID_W-1:0]    out_touch_number,
  output logic [COORD_W-1:0] out_pos_x,
  output logic [COORD_W-1:0] out_pos_y,
  output logic [TIME_W-1:0]  out_start_time,
  output logic               out_last_event
);

  // Configuration and persistent table
  logic [COORD_W-1:0] radius_r;
  logic [CNT_W-1:0]   tracked_r, tracked_nxt;
  logic [ID_W-1:0]    next_id_r;
  logic [COORD_W-1:0] slot_x_r  [MAX_POINTS];
  logic [COORD_W-1:0] slot_y_r  [MAX_POINTS];
  logic [ID_W-1:0]    slot_id_r [MAX_POINTS];
  logic [TIME_W-1:0]  slot_st_r [MAX_POINTS];

  // Frame copy and working table
  logic [NPTS_W-1:0]  pn_r;
  logic [COORD_W-1:0] px_r [IN_POINTS];
  logic [COORD_W-1:0] py_r [IN_POINTS];
  logic [TIME_W-1:0]  now_r;
  logic [CNT_W-1:0]   old_r;
  logic [WCNT_W-1:0]  cnt_r;
  logic [COORD_W-1:0] wx_r  [WORK_SIZE];
  logic [COORD_W-1:0] wy_r  [WORK_SIZE];
  logic [ID_W-1:0]    wid_r [WORK_SIZE];
  logic [TIME_W-1:0]  wst_r [WORK_SIZE];
  logic [WORK_SIZE-1:0] seen_r;

  // Pending and output words
  logic               pend_valid_r, pend_valid_nxt;
  ev_kind_t           pend_kind_r;
  logic [ID_W-1:0]    pend_id_r;
  logic [COORD_W-1:0] pend_x_r, pend_y_r;
  logic [TIME_W-1:0]  pend_st_r;
  logic               out_valid_r, out_valid_nxt;
  ev_kind_t           out_kind_r;
  logic [ID_W-1:0]    out_id_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [TIME_W-1:0]  out_st_r;
  logic               out_last_r;

  // Matcher and event selection
  logic [COORD_W-1:0] cur_x, cur_y;
  logic               match, moved, pt_new;
  logic [WIDX_W-1:0]  mj, rel_ix, new_ix;
  logic               rel_emit;
  logic               push_ev, to_out, out_free, can_push;
  ev_kind_t           ev_kind;
  logic [ID_W-1:0]    ev_id;
  logic [COORD_W-1:0] ev_x, ev_y;
  logic [TIME_W-1:0]  ev_st;
  logic [NPTS_W-1:0]  pn_sat;

  // Compaction
  logic [WORK_SIZE-1:0] keep;
  logic [WCNT_W-1:0]    nk;
  logic [WIDX_W-1:0]    sel0, sel1;

  function automatic logic near_f(input logic [COORD_W-1:0] a,
                                  input logic [COORD_W-1:0] b,
                                  input logic [COORD_W-1:0] r);
    logic [COORD_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d <= r;
  endfunction

  // Saturate the point count
  assign pn_sat = (in_point_count > NPTS_W'(PT_LIMIT)) ? NPTS_W'(PT_LIMIT)
                                                       : in_point_count;

  // Current point and first matching touch tracked before this frame
  assign cur_x = px_r[cmd.idx];
  assign cur_y = py_r[cmd.idx];

  always_comb begin
    match = 1'b0;
    mj    = '0;
    for (int j = 0; j < MAX_POINTS; j++) begin
      if (!match && (CNT_W'(j) < old_r) && near_f(cur_x, wx_r[j], radius_r)
          && near_f(cur_y, wy_r[j], radius_r)) begin
        match = 1'b1;
        mj    = WIDX_W'(j);
      end
    end
  end

  assign moved  = (cur_x != wx_r[mj]) || (cur_y != wy_r[mj]);
  assign pt_new = cmd.pt_step && !match;
  assign new_ix = cnt_r[WIDX_W-1:0];
  assign rel_ix = WIDX_W'(cmd.idx);
  assign rel_emit = !seen_r[rel_ix];

  // Pick the event word of this step
  always_comb begin
    if (cmd.rel_step) begin
      ev_kind = EV_RELEASE;
      ev_id   = wid_r[rel_ix];
      ev_x    = wx_r[rel_ix];
      ev_y    = wy_r[rel_ix];
      ev_st   = wst_r[rel_ix];
    end else if (match) begin
      ev_kind = EV_MOVE;
      ev_id   = wid_r[mj];
      ev_x    = cur_x;
      ev_y    = cur_y;
      ev_st   = wst_r[mj];
    end else begin
      ev_kind = EV_DOWN;
      ev_id   = next_id_r;
      ev_x    = cur_x;
      ev_y    = cur_y;
      ev_st   = now_r;
    end
  end

  // Pending word moves on when a newer word arrives or the frame ends
  assign out_free = !out_valid_r || !out_stall;
  assign can_push = !pend_valid_r || out_free;
  assign push_ev  = (cmd.pt_step && (!match || moved)) || (cmd.rel_step && rel_emit);
  assign to_out   = pend_valid_r && (push_ev || cmd.finish);

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (push_ev) begin
      pend_valid_nxt = 1'b1;
    end else if (cmd.finish) begin
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (to_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Survivors: matched old touches, then new ones, in table order
  always_comb begin
    nk   = '0;
    sel0 = '0;
    sel1 = '0;
    for (int i = 0; i < WORK_SIZE; i++) begin
      keep[i] = (WCNT_W'(i) < cnt_r)
                && ((WCNT_W'(i) >= WCNT_W'(old_r)) || seen_r[i]);
      if (keep[i]) begin
        if (nk == WCNT_W'(0)) begin
          sel0 = WIDX_W'(i);
        end else if (nk == WCNT_W'(1)) begin
          sel1 = WIDX_W'(i);
        end
        nk = nk + WCNT_W'(1);
      end
    end
    tracked_nxt = (nk > WCNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(nk);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= RADIUS_RESET;
      tracked_r    <= '0;
      next_id_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      if (pt_new) begin
        next_id_r <= next_id_r + ID_W'(1);
      end
      if (cmd.finish) begin
        tracked_r <= tracked_nxt;
      end
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Table and word registers
  always_ff @(posedge clk) begin
    // load the frame and copy the table
    if (cmd.load) begin
      pn_r    <= pn_sat;
      px_r[0] <= in_first_x;
      py_r[0] <= in_first_y;
      px_r[1] <= in_second_x;
      py_r[1] <= in_second_y;
      now_r   <= in_frame_time;
      old_r   <= tracked_r;
      cnt_r   <= WCNT_W'(tracked_r);
      seen_r  <= '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        wx_r[i]  <= slot_x_r[i];
        wy_r[i]  <= slot_y_r[i];
        wid_r[i] <= slot_id_r[i];
        wst_r[i] <= slot_st_r[i];
      end
    end
    // update a matched touch or open a new one
    if (cmd.pt_step) begin
      if (match) begin
        seen_r[mj] <= 1'b1;
        wx_r[mj]   <= cur_x;
        wy_r[mj]   <= cur_y;
      end else begin
        wx_r[new_ix]  <= cur_x;
        wy_r[new_ix]  <= cur_y;
        wid_r[new_ix] <= next_id_r;
        wst_r[new_ix] <= now_r;
        cnt_r         <= cnt_r + WCNT_W'(1);
      end
    end
    // write back the compacted table
    if (cmd.finish) begin
      if (nk >= WCNT_W'(1)) begin
        slot_x_r[0]  <= wx_r[sel0];
        slot_y_r[0]  <= wy_r[sel0];
        slot_id_r[0] <= wid_r[sel0];
        slot_st_r[0] <= wst_r[sel0];
      end
      if (nk >= WCNT_W'(2)) begin
        slot_x_r[1]  <= wx_r[sel1];
        slot_y_r[1]  <= wy_r[sel1];
        slot_id_r[1] <= wid_r[sel1];
        slot_st_r[1] <= wst_r[sel1];
      end
    end
    if (push_ev) begin
      pend_kind_r <= ev_kind;
      pend_id_r   <= ev_id;
      pend_x_r    <= ev_x;
      pend_y_r    <= ev_y;
      pend_st_r   <= ev_st;
    end
    if (to_out) begin
      out_kind_r <= pend_kind_r;
      out_id_r   <= pend_id_r;
      out_x_r    <= pend_x_r;
      out_y_r    <= pend_y_r;
      out_st_r   <= pend_st_r;
      out_last_r <= cmd.finish;
    end
  end

  // Status back to the controller
  assign st.n_pts    = pn_r;
  assign st.old_cnt  = old_r;
  assign st.pt_emit  = !match || moved;
  assign st.rel_emit = rel_emit;
  assign st.can_push = can_push;

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_kind_r;
  assign out_touch_number = out_id_r;
  assign out_pos_x        = out_x_r;
  assign out_pos_y        = out_y_r;
  assign out_start_time   = out_st_r;
  assign out_last_event   = out_last_r;

endmodule

[design/touch_point_tracker_unit.sv]
// A frame is accepted in the idle state, then steps through its points and
// the touches held before it (each pass made even when empty), then commits
// the table; an output stall can hold any step. A frame is taken only after
// the last commit. Event words pass a pending register, then the output register.
// Reset (synchronous, rst_n low): empty table, ident counter zero, radius 8.
// ----------------------------------------------------------------------------
// touch_point_tracker_unit
// Two-touch panel tracker: matches frame points to tracked touches and
// emits touch-down, move and release event words.
// ----------------------------------------------------------------------------
module touch_point_tracker_unit import tpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [NPTS_W-1:0]  in_point_count,
  input  logic [COORD_W-1:0] in_first_x,
  input  logic [COORD_W-1:0] in_first_y,
  input  logic [COORD_W-1:0] in_second_x,
  input  logic [COORD_W-1:0] in_second_y,
  input  logic [TIME_W-1:0]  in_frame_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_kind,
  output logic [ID_W-1:0]    out_touch_number,
  output logic [COORD_W-1:0] out_pos_x,
  output logic [COORD_W-1:0] out_pos_y,
  output logic [TIME_W-1:0]  out_start_time,
  output logic               out_last_event
);

  tpt_cmd_t    cmd;
  tpt_status_t st;

  // Frame sequencer
  tpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Table, matcher and event words
  tpt_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_point_count   (in_point_count),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_second_x      (in_second_x),
    .in_second_y      (in_second_y),
    .in_frame_time    (in_frame_time),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_touch_number (out_touch_number),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_start_time   (out_start_time),
    .out_last_event   (out_last_event)
  );

endmodule

[design/tpt_checker.sv]
// ----------------------------------------------------------------------------
// tpt_checker
// Port-level checks on the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tpt_checker import tpt_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_event_kind,
  input logic [ID_W-1:0]    out_touch_number,
  input logic [COORD_W-1:0] out_pos_x,
  input logic [COORD_W-1:0] out_pos_y,
  input logic [TIME_W-1:0]  out_start_time,
  input logic               out_last_event
);

  // Reset leaves the block idle with no word on offer
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("tracker not idle after reset");

  // A stalled event word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_touch_number)
      && $stable(out_pos_x) && $stable(out_pos_y)
      && $stable(out_start_time) && $stable(out_last_event)
      && $stable(out_event_kind))
    else $error("stalled event word changed");

  // Only the three event codes appear
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_kind == EV_DOWN) || (out_event_kind == EV_MOVE)
      || (out_event_kind == EV_RELEASE))
    else $error("undefined event code");

  // An accepted frame keeps the input side busy for its work
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("frame accepted too soon after another");

endmodule

bind touch_point_tracker_unit tpt_checker u_tpt_checker (.*);

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for touch_point_tracker_unit. Drives scan frames over
// the valid/stall input channel and predicts the touch-down, move and release
// words for each accepted frame in a scoreboard. Each word taken from the
// result channel is checked field by field. Covers a directed sweep of edge
// cases, finger-like random frames under several radius settings with random
// idling on both sides, and a long receiver hold-off.
// ----------------------------------------------------------------------------
import tpt_pkg::*;

typedef struct {
  ev_kind_t            kind;
  logic [ID_W-1:0]     ident;
  logic [COORD_W-1:0]  x;
  logic [COORD_W-1:0]  y;
  logic [TIME_W-1:0]   t0;
  logic                is_last;
} touch_word_t;

// Tracks the touch table and holds the event words still owed by the block
class touch_tracker_sb;
  logic [COORD_W-1:0] radius;
  int                 held;
  logic [COORD_W-1:0] slot_x [MAX_POINTS];
  logic [COORD_W-1:0] slot_y [MAX_POINTS];
  logic [ID_W-1:0]    slot_id [MAX_POINTS];
  logic [TIME_W-1:0]  slot_t0 [MAX_POINTS];
  logic [ID_W-1:0]    next_id;
  touch_word_t        owed_q [$];
  int                 errors;

  function new();
    radius  = RADIUS_RESET;
    held    = 0;
    next_id = '0;
    errors  = 0;
  endfunction

  function bit close(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
    return ((a > b) ? a - b : b - a) <= radius;
  endfunction

  // Work out the words one accepted frame causes and update the table
  function void note_frame(logic [NPTS_W-1:0] count, logic [COORD_W-1:0] x0,
                           logic [COORD_W-1:0] y0, logic [COORD_W-1:0] x1,
                           logic [COORD_W-1:0] y1, logic [TIME_W-1:0] now);
    logic [COORD_W-1:0] wx [WORK_SIZE];
    logic [COORD_W-1:0] wy [WORK_SIZE];
    logic [ID_W-1:0]    wid [WORK_SIZE];
    logic [TIME_W-1:0]  wt [WORK_SIZE];
    bit                 seen [WORK_SIZE];
    logic [COORD_W-1:0] px [IN_POINTS];
    logic [COORD_W-1:0] py [IN_POINTS];
    touch_word_t        frame_q [$];
    int                 n, old, cnt, hit, kept;
    n   = (count > PT_LIMIT) ? PT_LIMIT : count;
    old = held;
    cnt = old;
    px[0] = x0;
    py[0] = y0;
    px[1] = x1;
    py[1] = y1;
    for (int i = 0; i < WORK_SIZE; i++) begin
      seen[i] = 1'b0;
      wx[i] = '0;
      wy[i] = '0;
      wid[i] = '0;
      wt[i] = '0;
    end
    for (int i = 0; i < old; i++) begin
      wx[i]  = slot_x[i];
      wy[i]  = slot_y[i];
      wid[i] = slot_id[i];
      wt[i]  = slot_t0[i];
    end
    // match each point against touches held before this frame only
    for (int i = 0; i < n; i++) begin
      hit = -1;
      for (int j = 0; j < old && hit < 0; j++) begin
        if (close(px[i], wx[j]) && close(py[i], wy[j])) hit = j;
      end
      if (hit >= 0) begin
        seen[hit] = 1'b1;
        if (px[i] != wx[hit] || py[i] != wy[hit]) begin
          wx[hit] = px[i];
          wy[hit] = py[i];
          frame_q.push_back('{EV_MOVE, wid[hit], wx[hit], wy[hit], wt[hit], 1'b0});
        end
      end else if (cnt < WORK_SIZE) begin
        wid[cnt] = next_id;
        next_id  = next_id + 1'b1;
        wx[cnt]  = px[i];
        wy[cnt]  = py[i];
        wt[cnt]  = now;
        frame_q.push_back('{EV_DOWN, wid[cnt], wx[cnt], wy[cnt], wt[cnt], 1'b0});
        cnt++;
      end
    end
    // release unseen old touches in slot order, compact the survivors
    kept = 0;
    for (int i = 0; i < cnt; i++) begin
      if (i < old && !seen[i]) begin
        frame_q.push_back('{EV_RELEASE, wid[i], wx[i], wy[i], wt[i], 1'b0});
      end else if (kept < MAX_POINTS) begin
        slot_x[kept]  = wx[i];
        slot_y[kept]  = wy[i];
        slot_id[kept] = wid[i];
        slot_t0[kept] = wt[i];
        kept++;
      end
    end
    held = kept;
    if (frame_q.size() > 0) frame_q[frame_q.size()-1].is_last = 1'b1;
    foreach (frame_q[k]) owed_q.push_back(frame_q[k]);
  endfunction

  function void compare(string field, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endfunction

  // Check one word taken from the result channel against the oldest owed word
  function void check_word(logic [1:0] kind, logic [ID_W-1:0] ident,
                           logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [TIME_W-1:0] t0, logic is_last);
    touch_word_t w;
    if (owed_q.size() == 0) begin
      $error("unexpected event word: kind %0d touch %0h", kind, ident);
      errors++;
      return;
    end
    w = owed_q.pop_front();
    compare("event_kind", TIME_W'(w.kind), TIME_W'(kind));
    compare("touch_number", TIME_W'(w.ident), TIME_W'(ident));
    compare("pos_x", TIME_W'(w.x), TIME_W'(x));
    compare("pos_y", TIME_W'(w.y), TIME_W'(y));
    compare("start_time", w.t0, t0);
    compare("last_event", TIME_W'(w.is_last), TIME_W'(is_last));
  endfunction
endclass

module tb;

  localparam int CYCLE_LIMIT   = 200_000;
  localparam int SETTLE_CYCLES = 16;

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               cfg_we         = 1'b0;
  logic [COORD_W-1:0] cfg_wdata      = '0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [NPTS_W-1:0]  in_point_count = '0;
  logic [COORD_W-1:0] in_first_x     = '0;
  logic [COORD_W-1:0] in_first_y     = '0;
  logic [COORD_W-1:0] in_second_x    = '0;
  logic [COORD_W-1:0] in_second_y    = '0;
  logic [TIME_W-1:0]  in_frame_time  = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [1:0]         out_event_kind;
  logic [ID_W-1:0]    out_touch_number;
  logic [COORD_W-1:0] out_pos_x;
  logic [COORD_W-1:0] out_pos_y;
  logic [TIME_W-1:0]  out_start_time;
  logic               out_last_event;

  touch_tracker_sb sb = new();

  int          send_idle_pct = 16;
  int          recv_idle_pct = 70;
  int          hold_len      = 0;
  int          hold_left     = 0;
  int          cycle_cnt     = 0;
  int          cur_radius    = int'(RADIUS_RESET);
  int          fing_n        = 0;
  int          fing_x [2];
  int          fing_y [2];
  logic [TIME_W-1:0] frame_clock = '0;

  touch_point_tracker_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_point_count   (in_point_count),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_second_x      (in_second_x),
    .in_second_y      (in_second_y),
    .in_frame_time    (in_frame_time),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_touch_number (out_touch_number),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_start_time   (out_start_time),
    .out_last_event   (out_last_event)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up if the run hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Take result words, stall at random or for a requested long hold-off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_event_kind, out_touch_number, out_pos_x, out_pos_y,
                    out_start_time, out_last_event);
    end
    if (hold_len > 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one frame word, idling first at random; return once it is taken
  task automatic send_frame(input logic [NPTS_W-1:0] count, input logic [COORD_W-1:0] x0,
                            input logic [COORD_W-1:0] y0, input logic [COORD_W-1:0] x1,
                            input logic [COORD_W-1:0] y1, input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_point_count <= count;
    in_first_x     <= x0;
    in_first_y     <= y0;
    in_second_x    <= x1;
    in_second_y    <= y1;
    in_frame_time  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_frame(count, x0, y0, x1, y1, t);
  endtask

  // Hold the input idle until every owed word has arrived, then let it settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_radius(input int r);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= COORD_W'(r);
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.radius  = COORD_W'(r);
    cur_radius = r;
  endtask

  function automatic int drift(int c, int step);
    int v;
    v = c + int'($urandom_range(2 * step)) - step;
    if (v < 0) v = 0;
    if (v > 2047) v = 2047;
    return v;
  endfunction

  // Mostly fingers drifting within the radius, touching down and lifting;
  // the rest is noise with random counts and coordinates
  task automatic random_frame();
    logic [NPTS_W-1:0]  count;
    logic [COORD_W-1:0] ax, ay, bx, by;
    int                 step;
    step = (cur_radius < 24) ? cur_radius : 24;
    ax = COORD_W'($urandom_range(2047));
    ay = COORD_W'($urandom_range(2047));
    bx = COORD_W'($urandom_range(2047));
    by = COORD_W'($urandom_range(2047));
    if ($urandom_range(99) < 75) begin
      for (int f = 0; f < fing_n; f++) begin
        fing_x[f] = drift(fing_x[f], step);
        fing_y[f] = drift(fing_y[f], step);
      end
      if (fing_n > 0 && $urandom_range(9) == 0) begin
        if (fing_n == 2 && $urandom_range(1) == 0) begin
          fing_x[0] = fing_x[1];
          fing_y[0] = fing_y[1];
        end
        fing_n--;
      end else if (fing_n < 2 && $urandom_range(3) == 0) begin
        fing_x[fing_n] = $urandom_range(2047);
        fing_y[fing_n] = $urandom_range(2047);
        fing_n++;
      end
      count = NPTS_W'(fing_n);
      if (fing_n == 2 && $urandom_range(7) == 0) count = 2'd3;
      if (fing_n == 2 && $urandom_range(1) == 1) begin
        ax = COORD_W'(fing_x[1]);
        ay = COORD_W'(fing_y[1]);
        bx = COORD_W'(fing_x[0]);
        by = COORD_W'(fing_y[0]);
      end else begin
        if (fing_n > 0) begin
          ax = COORD_W'(fing_x[0]);
          ay = COORD_W'(fing_y[0]);
        end
        if (fing_n > 1) begin
          bx = COORD_W'(fing_x[1]);
          by = COORD_W'(fing_y[1]);
        end
      end
    end else begin
      count = NPTS_W'($urandom_range(3));
    end
    frame_clock = frame_clock + $urandom_range(1, 20000);
    if ($urandom_range(19) == 0) frame_clock = $urandom();
    send_frame(count, ax, ay, bx, by, frame_clock);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset radius of 8
    send_frame(2'd0, 11'd0, 11'd0, 11'd0, 11'd0, 32'd0);               // empty table, empty frame
    send_frame(2'd1, 11'd0, 11'd0, 11'd2047, 11'd2047, 32'd0);         // down at origin
    send_frame(2'd1, 11'd0, 11'd0, 11'd5, 11'd5, 32'd1);               // still, no word
    send_frame(2'd1, 11'd8, 11'd8, 11'd0, 11'd0, 32'd2);               // move at the radius edge
    send_frame(2'd1, 11'd17, 11'd8, 11'd0, 11'd0, 32'd3);              // just outside: down, release
    send_frame(2'd2, 11'd2047, 11'd2047, 11'd2039, 11'd2039, 32'd4);   // two downs, one release
    send_frame(2'd3, 11'd2046, 11'd2046, 11'd2040, 11'd2040, 32'd5);   // count saturates, one touch twice
    send_frame(2'd2, 11'd2040, 11'd2040, 11'd2040, 11'd2040, 32'd6);   // matched twice, unmoved
    send_frame(2'd2, 11'd1024, 11'd0, 11'd0, 11'd1024, 32'd7);
    send_frame(2'd2, 11'd0, 11'd2047, 11'd2047, 11'd0, 32'hFFFF_FFFF); // four words
    send_frame(2'd2, 11'd4, 11'd2043, 11'd2043, 11'd4, 32'd9);         // both move
    send_frame(2'd2, 11'd2043, 11'd4, 11'd4, 11'd2043, 32'd10);        // swapped order, unmoved
    send_frame(2'd0, 11'd0, 11'd0, 11'd0, 11'd0, 32'd11);              // release all
    send_frame(2'd0, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 32'd12);      // empty again
    send_frame(2'd2, 11'd100, 11'd100, 11'd100, 11'd100, 32'd13);      // same spot, two new touches
    send_frame(2'd1, 11'h555, 11'h2AA, 11'h2AA, 11'h555, 32'hAAAA_AAAA);
    send_frame(2'd2, 11'h2AA, 11'h555, 11'h555, 11'h2AA, 32'h5555_5555);
    send_frame(2'd3, 11'h2AA, 11'h555, 11'h7FF, 11'h000, 32'h8000_0001);
    send_frame(2'd1, 11'h7FF, 11'h000, 11'h2AA, 11'h555, 32'h7FFF_FFFE);

    // Sender idles lightly, receiver heavily
    set_radius(16);
    repeat (25) random_frame();

    // And the other way round, with exact matching only
    send_idle_pct = 70;
    recv_idle_pct = 16;
    set_radius(0);
    repeat (25) random_frame();

    // No idling; a long receiver hold-off fills the block, then the sender pauses
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_radius(2047);
    hold_len = 200;
    repeat (12) random_frame();
    drain();
    repeat (8) random_frame();

    set_radius($urandom_range(1, 100));
    repeat (15) random_frame();

    drain();
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/tpt_pkg.sv
design/tpt_ctrl.sv
design/tpt_datapath.sv
design/touch_point_tracker_unit.sv
design/tpt_checker.sv
dv/tb.sv
